### hdl/rcwta_pkg.sv
`default_nettype none
package rcwta_pkg;

  localparam int MAX_ROWS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int LOG2_MAX      = 10;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED        = 2'd3;

  localparam logic [3:0]  TEX_LOG2_RST   = 4'd6;
  localparam logic [11:0] SCREEN_H_RST   = 12'd480;

  typedef enum logic [1:0] {
    FACE_SOUTH,
    FACE_NORTH,
    FACE_EAST,
    FACE_WEST
  } face_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIT,
    ST_DIV,
    ST_POS,
    ST_EMIT
  } state_e;

  function automatic logic [3:0] clamp_log2(input logic [3:0] v);
    clamp_log2 = (v > 4'(LOG2_MAX)) ? 4'(LOG2_MAX) : v;
  endfunction

endpackage
`default_nettype wire

### hdl/raycast_wall_texel_addresser_core.sv
// channel   direction  beat content
// in        sink       one wall slice: side, ray, distance, position, height, span
// out       source     one texel address per screen row, up to MaxRows, last on final row
// cfg       sink       register index and write data
//
// an item is latched, then goes through the hit multiply, the bit-serial step
// division and the start multiply, then emits one row per cycle while out is
// ready; one shared multiplier serves both multiplies
// in is ready only while idle; an empty span returns to idle at once
// a stalled out beat holds; reset returns to idle with default registers
`default_nettype none
module raycast_wall_texel_addresser_core #(
  parameter int MaxRows  = rcwta_pkg::MAX_ROWS_DEF,
  parameter int FracBits = rcwta_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             hit_side_i,
  input  wire logic signed [15:0]               dir_x_i,
  input  wire logic signed [15:0]               dir_y_i,
  input  wire logic [25:0]                      perp_dist_i,
  input  wire logic [25:0]                      pos_x_i,
  input  wire logic [25:0]                      pos_y_i,
  input  wire logic [15:0]                      line_height_i,
  input  wire logic [11:0]                      row_start_i,
  input  wire logic [11:0]                      row_end_i,
  input  wire logic [11:0]                      column_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [11:0]                           out_column_o,
  output logic [11:0]                           out_row_o,
  output logic [1:0]                            face_o,
  output logic [9:0]                            tex_x_o,
  output logic [9:0]                            tex_y_o,
  output logic [19:0]                           texel_index_o,
  output logic                                  last_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [rcwta_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [11:0]                      cfg_data_i
);
  import rcwta_pkg::*;

  localparam int NumW  = FracBits + LOG2_MAX + 1;
  localparam int CntW  = $clog2(NumW);
  localparam int MulAW = (NumW + 1 > 27) ? NumW + 1 : 27;
  localparam int ProdW = MulAW + 17;
  localparam int KW    = $clog2(MaxRows + 1);

  state_e state_q, state_d;

  logic [3:0]  wl_cfg_q, hl_cfg_q;
  logic [11:0] sh_q;

  logic               side_q;
  logic signed [15:0] dx_q, dy_q;
  logic [25:0]        perp_q, px_q, py_q;
  logic [15:0]        lineh_q;
  logic [11:0]        row_q, col_q;
  logic [1:0]         face_q;
  logic [9:0]         tx_q;
  logic [16:0]        offset_q;
  logic [KW-1:0]      n_q, k_q;
  logic [CntW-1:0]    cnt_q;
  logic [15:0]        rem_q;
  logic [NumW-1:0]    quot_q;
  logic signed [ProdW-1:0] tpos_q;

  logic [3:0]  wl, hl;
  logic [9:0]  mask_w, mask_h;
  logic        in_beat, out_beat, empty_span;
  logic [11:0] span;
  logic [KW-1:0] n_new;
  logic        last_row;

  logic signed [MulAW-1:0] mul_a;
  logic signed [16:0]      mul_b;
  logic signed [ProdW-1:0] prod;

  logic [29:0]          hit30;
  logic [FracBits-1:0]  frac;
  logic [FracBits+9:0]  tx_wide;
  logic [9:0]           tx_raw, tx_new;
  logic                 mirror;

  logic [16:0] trial;
  logic        num_bit, qbit;
  logic [15:0] rem_new;

  logic [9:0] ty;

  assign wl     = clamp_log2(wl_cfg_q);
  assign hl     = clamp_log2(hl_cfg_q);
  assign mask_w = 10'((11'd1 << wl) - 11'd1);
  assign mask_h = 10'((11'd1 << hl) - 11'd1);

  assign in_beat    = in_valid_i && in_ready_o;
  assign out_beat   = out_valid_o && out_ready_i;
  assign empty_span = (line_height_i == 16'd0) || (row_start_i >= row_end_i);
  assign span       = row_end_i - row_start_i;
  assign n_new      = (span > 12'(MaxRows)) ? KW'(MaxRows) : KW'(span);
  assign last_row   = (k_q == n_q - KW'(1));

  // shared multiplier
  always_comb begin
    if (state_q == ST_HIT) begin
      mul_a = MulAW'({1'b0, perp_q});
      mul_b = side_q ? {dx_q[15], dx_q} : {dy_q[15], dy_q};
    end else begin
      mul_a = MulAW'({1'b0, quot_q});
      mul_b = offset_q;
    end
  end
  assign prod = mul_a * mul_b;

  // texture column
  assign hit30   = 30'({side_q ? px_q : py_q, 14'd0}) + prod[29:0];
  assign frac    = hit30[29 -: FracBits];
  assign tx_wide = ({10'd0, frac} << wl) >> FracBits;
  assign tx_raw  = tx_wide[9:0];
  assign mirror  = (!side_q && !dx_q[15] && (dx_q != 16'sd0)) || (side_q && dy_q[15]);
  assign tx_new  = (mirror ? ~tx_raw : tx_raw) & mask_w;

  // restoring division step
  assign num_bit = (int'(cnt_q) == int'(hl) + FracBits);
  assign trial   = {rem_q, num_bit};
  assign qbit    = (trial >= {1'b0, lineh_q});
  assign rem_new = qbit ? 16'(trial - {1'b0, lineh_q}) : trial[15:0];

  // texture row, truncated toward zero
  assign ty = (tpos_q[FracBits+9:FracBits]
              + {9'd0, tpos_q[ProdW-1] && (tpos_q[FracBits-1:0] != '0)}) & mask_h;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat && !empty_span) state_d = ST_HIT;
      end
      ST_HIT:  state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_POS;
      end
      ST_POS:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_beat && last_row) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o  = 1'b1;
      ST_EMIT: out_valid_o = 1'b1;
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  assign cfg_ready_o   = 1'b1;
  assign out_column_o  = col_q;
  assign out_row_o     = row_q;
  assign face_o        = face_q;
  assign tex_x_o       = tx_q;
  assign tex_y_o       = ty;
  assign texel_index_o = 20'({10'd0, ty} << wl) | {10'd0, tx_q};
  assign last_o        = last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wl_cfg_q <= TEX_LOG2_RST;
      hl_cfg_q <= TEX_LOG2_RST;
      sh_q     <= SCREEN_H_RST;
      k_q      <= '0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_TEX_WIDTH_LOG2:  wl_cfg_q <= cfg_data_i[3:0];
          CFG_TEX_HEIGHT_LOG2: hl_cfg_q <= cfg_data_i[3:0];
          CFG_SCREEN_HEIGHT:   sh_q     <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_HIT:  cnt_q <= CntW'(NumW - 1);
        ST_DIV:  cnt_q <= cnt_q - CntW'(1);
        ST_POS:  k_q   <= '0;
        ST_EMIT: begin
          if (out_beat) k_q <= k_q + KW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          side_q   <= hit_side_i;
          dx_q     <= dir_x_i;
          dy_q     <= dir_y_i;
          perp_q   <= perp_dist_i;
          px_q     <= pos_x_i;
          py_q     <= pos_y_i;
          lineh_q  <= line_height_i;
          row_q    <= row_start_i;
          col_q    <= column_i;
          n_q      <= n_new;
          face_q   <= hit_side_i ? (dir_y_i[15] ? FACE_NORTH : FACE_SOUTH)
                                 : (dir_x_i[15] ? FACE_EAST : FACE_WEST);
          offset_q <= {5'd0, row_start_i} - {6'd0, sh_q[11:1]}
                    + {2'd0, line_height_i[15:1]};
        end
      end
      ST_HIT: begin
        tx_q   <= tx_new;
        rem_q  <= '0;
        quot_q <= '0;
      end
      ST_DIV: begin
        rem_q  <= rem_new;
        quot_q <= {quot_q[NumW-2:0], qbit};
      end
      ST_POS: tpos_q <= prod;
      ST_EMIT: begin
        if (out_beat) begin
          tpos_q <= tpos_q + ProdW'(quot_q);
          row_q  <= row_q + 12'd1;
        end
      end
      default: ;
    endcase
  end

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("in ready while out valid");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && last_o) |=> (!out_valid_o && in_ready_o))
    else $error("rows continue after last");

  a_row_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (k_q < n_q))
    else $error("row count beyond span");

  a_div_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |=> (state_q == ST_DIV || state_q == ST_POS))
    else $error("division left early");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && !last_o) |=> (out_valid_o && out_row_o == 12'($past(out_row_o) + 12'd1)))
    else $error("row did not advance");

endmodule
`default_nettype wire
